>>> sv/usph_pkg.sv
// Shared types, widths and constants of the UV sphere tessellator.
// No dependencies; the cell modules and the top level use it by scoped names.

package usph_pkg;

  // Field and register widths
  localparam int SEG_W   = 9;
  localparam int RAD_W   = 16;
  localparam int IDX_W   = 17;
  localparam int POS_W   = 17;
  localparam int NORM_W  = 16;
  localparam int REM_W   = SEG_W + 1;
  localparam int CFG_W   = 2;
  localparam int MAX_SEGMENTS = 256;

  // Angle divider and CORDIC dimensions
  localparam int DIV_STEPS    = 33;
  localparam int ANG_W        = 32;
  localparam int CORDIC_STEPS = 16;
  localparam logic signed [ANG_W-1:0] CORDIC_GAIN_START = 32'sh26DD3B6A;

  // Opcodes
  localparam logic OP_VERTEX = 1'b0;
  localparam logic OP_QUAD   = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_W-1:0] REG_LAT_SEGMENTS = 2'd0;
  localparam logic [CFG_W-1:0] REG_LON_SEGMENTS = 2'd1;
  localparam logic [CFG_W-1:0] REG_SPHERE_RADIUS = 2'd2;

  // Item tag carried alongside the arithmetic of every stage
  typedef struct packed {
    logic             valid;
    logic             op;
    logic [IDX_W-1:0] cur;
  } tag_t;

  // One lane of the restoring angle divider
  typedef struct packed {
    logic [REM_W-1:0]     r;
    logic [SEG_W-1:0]     d;
    logic                 a0;
    logic [DIV_STEPS-1:0] q;
  } div_lane_t;

  // One lane of the rotation CORDIC
  typedef struct packed {
    logic signed [ANG_W-1:0] x;
    logic signed [ANG_W-1:0] y;
    logic signed [ANG_W-1:0] z;
    logic                    flip;
  } cor_lane_t;

  // Arctangent of 2^-i as a fraction of a full turn
  function automatic logic signed [ANG_W-1:0] atan_turn(input int i);
    logic signed [ANG_W-1:0] v;
    case (i)
      0:  v = 32'sh20000000;
      1:  v = 32'sh12E4051E;
      2:  v = 32'sh09FB385B;
      3:  v = 32'sh051111D4;
      4:  v = 32'sh028B0D43;
      5:  v = 32'sh0145D7E1;
      6:  v = 32'sh00A2F61E;
      7:  v = 32'sh00517C55;
      8:  v = 32'sh0028BE53;
      9:  v = 32'sh00145F2F;
      10: v = 32'sh000A2F98;
      11: v = 32'sh000517CC;
      12: v = 32'sh00028BE6;
      13: v = 32'sh000145F3;
      14: v = 32'sh0000A2F9;
      15: v = 32'sh0000517D;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> sv/uv_sphere_tessellator.sv
// Top level of the UV sphere tessellator: config registers, grid setup,
// divider and CORDIC cell chains, product stages and the result sequencer.
// Depends on usph_pkg, usph_div_cell and usph_cordic_cell.
//
//  port group   dir  payload                                            done when
//  s_axis_*     in   tdata: lat_step, lon_step; tuser: opcode           tvalid & tready
//  m_axis_*     out  tdata: pos_x..z, norm_x..z, vertex_index; tlast    tvalid & tready
//  cfg_*        in   cfg_index selects register, cfg_data value         cfg_we
//
// One request enters per cycle while s_axis_tready is high; a vertex request
// gives one result, a quad request holds the result register for six transfers.
// The accepting edge loads the setup stage; the first result is offered after
// 33 divider cells, a fold stage, 16 CORDIC cells, four unfold, product and
// rounding stages and the result register.
// All stages advance together; a stall on m_axis freezes the chain and drops
// s_axis_tready. Reset (rst, synchronous) clears every stage valid and loads
// the register defaults.

module uv_sphere_tessellator #(
  parameter int MAX_SEGMENTS = usph_pkg::MAX_SEGMENTS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [23:0]               s_axis_tdata,  // lat_step[8:0], lon_step[17:9], zero pad
  input  logic                      s_axis_tuser,  // opcode
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [119:0]              m_axis_tdata,  // pos_x, pos_y, pos_z, norm_x, norm_y,
                                                   // norm_z, vertex_index, zero pad
  output logic                      m_axis_tlast,
  input  logic                      cfg_we,
  input  logic [usph_pkg::CFG_W-1:0] cfg_index,
  input  logic [usph_pkg::RAD_W-1:0] cfg_data
);

  localparam int SEG_W  = usph_pkg::SEG_W;
  localparam int IDX_W  = usph_pkg::IDX_W;
  localparam int ANG_W  = usph_pkg::ANG_W;
  localparam int DSTEPS = usph_pkg::DIV_STEPS;
  localparam int CSTEPS = usph_pkg::CORDIC_STEPS;

  // Configuration registers
  logic [SEG_W-1:0]          lat_segments;
  logic [SEG_W-1:0]          lon_segments;
  logic [usph_pkg::RAD_W-1:0] sphere_radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      lat_segments  <= SEG_W'(16);
      lon_segments  <= SEG_W'(16);
      sphere_radius <= usph_pkg::RAD_W'(256);
    end else if (cfg_we) begin
      unique case (cfg_index)
        usph_pkg::REG_LAT_SEGMENTS:  lat_segments  <= cfg_data[SEG_W-1:0];
        usph_pkg::REG_LON_SEGMENTS:  lon_segments  <= cfg_data[SEG_W-1:0];
        usph_pkg::REG_SPHERE_RADIUS: sphere_radius <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp the band counts to the supported range
  logic [SEG_W-1:0] seg_n;
  logic [SEG_W-1:0] seg_m;

  always_comb begin
    if (lat_segments == '0) seg_n = SEG_W'(1);
    else if (int'(lat_segments) > MAX_SEGMENTS) seg_n = SEG_W'(MAX_SEGMENTS);
    else seg_n = lat_segments;
    if (lon_segments == '0) seg_m = SEG_W'(1);
    else if (int'(lon_segments) > MAX_SEGMENTS) seg_m = SEG_W'(MAX_SEGMENTS);
    else seg_m = lon_segments;
  end

  // Chain enable and result sequencer state
  logic                   en;
  logic                   out_valid;
  logic                   out_op;
  logic [IDX_W-1:0]       out_cur;
  logic [2:0]             cnt;
  logic                   out_last;

  assign out_last      = (out_op == usph_pkg::OP_VERTEX) || (cnt == 3'd5);
  assign en            = !out_valid || (m_axis_tready && out_last);
  assign s_axis_tready = en;

  // Setup stage: clamp grid indexes, form mesh index and divider operands
  logic [SEG_W-1:0] lat_in;
  logic [SEG_W-1:0] lon_in;
  logic [SEG_W-1:0] lat_lim;
  logic [SEG_W-1:0] lon_lim;
  logic [SEG_W-1:0] lat_c;
  logic [SEG_W-1:0] lon_c;
  logic [2*SEG_W+1:0] cur_full;

  usph_pkg::tag_t      div_tag [0:DSTEPS];
  usph_pkg::div_lane_t div_th  [0:DSTEPS];
  usph_pkg::div_lane_t div_ph  [0:DSTEPS];

  assign lat_in = s_axis_tdata[SEG_W-1:0];
  assign lon_in = s_axis_tdata[2*SEG_W-1:SEG_W];

  always_comb begin
    lat_lim  = (s_axis_tuser == usph_pkg::OP_QUAD) ? seg_n - SEG_W'(1) : seg_n;
    lon_lim  = (s_axis_tuser == usph_pkg::OP_QUAD) ? seg_m - SEG_W'(1) : seg_m;
    lat_c    = (lat_in > lat_lim) ? lat_lim : lat_in;
    lon_c    = (lon_in > lon_lim) ? lon_lim : lon_in;
    cur_full = {1'b0, lat_c} * ({1'b0, seg_m} + (SEG_W+1)'(1)) + (2*SEG_W+2)'(lon_c);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_tag[0].valid <= 1'b0;
    end else if (en) begin
      div_tag[0].valid <= s_axis_tvalid;
      div_tag[0].op    <= s_axis_tuser;
      div_tag[0].cur   <= cur_full[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_th[0].r  <= {1'b0, lat_c} >> 1;
      div_th[0].a0 <= lat_c[0];
      div_th[0].d  <= seg_n;
      div_th[0].q  <= '0;
      div_ph[0].r  <= {1'b0, lon_c};
      div_ph[0].a0 <= 1'b0;
      div_ph[0].d  <= seg_m;
      div_ph[0].q  <= '0;
    end
  end

  // Divider chain: one quotient bit per cell
  for (genvar i = 0; i < DSTEPS; i++) begin : g_div
    usph_div_cell #(.STEP(i)) u_cell (
      .clk    (clk),
      .rst    (rst),
      .en     (en),
      .tag_in (div_tag[i]),
      .th_in  (div_th[i]),
      .ph_in  (div_ph[i]),
      .tag_out(div_tag[i+1]),
      .th_out (div_th[i+1]),
      .ph_out (div_ph[i+1])
    );
  end

  // Fold stage: bring each angle into the right half plane
  usph_pkg::tag_t      cor_tag [0:CSTEPS];
  usph_pkg::cor_lane_t cor_th  [0:CSTEPS];
  usph_pkg::cor_lane_t cor_ph  [0:CSTEPS];

  function automatic usph_pkg::cor_lane_t fold(input logic [ANG_W-1:0] a);
    logic [ANG_W-1:0]    s;
    usph_pkg::cor_lane_t o;
    s      = a + 32'h4000_0000;
    o.flip = s[ANG_W-1];
    o.z    = $signed(o.flip ? a - 32'h8000_0000 : a);
    o.x    = usph_pkg::CORDIC_GAIN_START;
    o.y    = '0;
    return o;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      cor_tag[0].valid <= 1'b0;
    end else if (en) begin
      cor_tag[0] <= div_tag[DSTEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cor_th[0] <= fold(div_th[DSTEPS].q[ANG_W-1:0]);
      cor_ph[0] <= fold(div_ph[DSTEPS].q[ANG_W-1:0]);
    end
  end

  // CORDIC chain: one micro-rotation per cell
  for (genvar i = 0; i < CSTEPS; i++) begin : g_cor
    usph_cordic_cell #(.STEP(i)) u_cell (
      .clk    (clk),
      .rst    (rst),
      .en     (en),
      .tag_in (cor_tag[i]),
      .th_in  (cor_th[i]),
      .ph_in  (cor_ph[i]),
      .tag_out(cor_tag[i+1]),
      .th_out (cor_th[i+1]),
      .ph_out (cor_ph[i+1])
    );
  end

  // Unfold stage: negate results of folded angles
  usph_pkg::tag_t          fx_tag;
  logic signed [ANG_W-1:0] ct;
  logic signed [ANG_W-1:0] st;
  logic signed [ANG_W-1:0] cp;
  logic signed [ANG_W-1:0] sp;

  always_ff @(posedge clk) begin
    if (rst) begin
      fx_tag.valid <= 1'b0;
    end else if (en) begin
      fx_tag <= cor_tag[CSTEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ct <= cor_th[CSTEPS].flip ? -cor_th[CSTEPS].x : cor_th[CSTEPS].x;
      st <= cor_th[CSTEPS].flip ? -cor_th[CSTEPS].y : cor_th[CSTEPS].y;
      cp <= cor_ph[CSTEPS].flip ? -cor_ph[CSTEPS].x : cor_ph[CSTEPS].x;
      sp <= cor_ph[CSTEPS].flip ? -cor_ph[CSTEPS].y : cor_ph[CSTEPS].y;
    end
  end

  // Direction products
  usph_pkg::tag_t            m1_tag;
  logic signed [2*ANG_W-1:0] p0;
  logic signed [2*ANG_W-1:0] p2;
  logic signed [ANG_W-1:0]   p1;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_tag.valid <= 1'b0;
    end else if (en) begin
      m1_tag <= fx_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0 <= st * cp;
      p2 <= st * sp;
      p1 <= ct;
    end
  end

  // Round the products back to Q2.30
  usph_pkg::tag_t            c_tag;
  logic signed [ANG_W-1:0]   c0;
  logic signed [ANG_W-1:0]   c1;
  logic signed [ANG_W-1:0]   c2;
  logic signed [2*ANG_W-1:0] p0_r;
  logic signed [2*ANG_W-1:0] p2_r;

  assign p0_r = p0 + 64'sd536870912;
  assign p2_r = p2 + 64'sd536870912;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_tag.valid <= 1'b0;
    end else if (en) begin
      c_tag <= m1_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c0 <= p0_r[ANG_W+29:30];
      c1 <= p1;
      c2 <= p2_r[ANG_W+29:30];
    end
  end

  // Scale by the radius and form the normals
  function automatic logic signed [usph_pkg::NORM_W-1:0] to_norm(
    input logic signed [ANG_W-1:0] c
  );
    logic signed [ANG_W:0]   t;
    logic signed [ANG_W-16:0] v;
    t = {c[ANG_W-1], c} + 33'sd32768;
    v = t[ANG_W:16];
    if (v > 17'sd16384) v = 17'sd16384;
    else if (v < -17'sd16384) v = -17'sd16384;
    return v[usph_pkg::NORM_W-1:0];
  endfunction

  usph_pkg::tag_t                      m2_tag;
  logic signed [ANG_W+16:0]            q0;
  logic signed [ANG_W+16:0]            q1;
  logic signed [ANG_W+16:0]            q2;
  logic signed [usph_pkg::NORM_W-1:0]  n0;
  logic signed [usph_pkg::NORM_W-1:0]  n1;
  logic signed [usph_pkg::NORM_W-1:0]  n2;
  logic signed [usph_pkg::RAD_W:0]     rad_s;

  assign rad_s = $signed({1'b0, sphere_radius});

  always_ff @(posedge clk) begin
    if (rst) begin
      m2_tag.valid <= 1'b0;
    end else if (en) begin
      m2_tag <= c_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q0 <= rad_s * c0;
      q1 <= rad_s * c1;
      q2 <= rad_s * c2;
      n0 <= to_norm(c0);
      n1 <= to_norm(c1);
      n2 <= to_norm(c2);
    end
  end

  // Round and clamp positions to Q8.8
  function automatic logic signed [usph_pkg::POS_W-1:0] to_pos(
    input logic signed [ANG_W+16:0] p
  );
    logic signed [ANG_W+17:0] t;
    logic signed [19:0]       v;
    t = {p[ANG_W+16], p} + 50'sd536870912;
    v = t[49:30];
    if (v > 20'sd65535) v = 20'sd65535;
    else if (v < -20'sd65535) v = -20'sd65535;
    return v[usph_pkg::POS_W-1:0];
  endfunction

  // Result register and quad sequencer
  logic signed [usph_pkg::POS_W-1:0]  pos_x;
  logic signed [usph_pkg::POS_W-1:0]  pos_y;
  logic signed [usph_pkg::POS_W-1:0]  pos_z;
  logic signed [usph_pkg::NORM_W-1:0] norm_x;
  logic signed [usph_pkg::NORM_W-1:0] norm_y;
  logic signed [usph_pkg::NORM_W-1:0] norm_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      cnt       <= '0;
    end else if (en) begin
      out_valid <= m2_tag.valid;
      cnt       <= '0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      cnt <= cnt + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_op  <= m2_tag.op;
      out_cur <= m2_tag.cur;
      pos_x   <= to_pos(q0);
      pos_y   <= to_pos(q1);
      pos_z   <= to_pos(q2);
      norm_x  <= n0;
      norm_y  <= n1;
      norm_z  <= n2;
    end
  end

  // Corner offset for each transfer of a quad
  logic [SEG_W+1:0] offs;
  logic [IDX_W-1:0] vertex_index;
  logic             is_quad;

  always_comb begin
    case (cnt)
      3'd1, 3'd4: offs = (SEG_W+2)'(seg_m) + (SEG_W+2)'(1);
      3'd2, 3'd3: offs = (SEG_W+2)'(1);
      3'd5:       offs = (SEG_W+2)'(seg_m) + (SEG_W+2)'(2);
      default:    offs = '0;
    endcase
  end

  assign is_quad      = (out_op == usph_pkg::OP_QUAD);
  assign vertex_index = out_cur + IDX_W'(offs);

  assign m_axis_tvalid = out_valid;
  assign m_axis_tlast  = out_last;
  assign m_axis_tdata  = {4'b0,
                          vertex_index,
                          is_quad ? '0 : norm_z,
                          is_quad ? '0 : norm_y,
                          is_quad ? '0 : norm_x,
                          is_quad ? '0 : pos_z,
                          is_quad ? '0 : pos_y,
                          is_quad ? '0 : pos_x};

  // A vertex result is always the final transfer of its request
  a_vertex_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_op == usph_pkg::OP_VERTEX |-> m_axis_tlast)
    else $error("vertex result without tlast");

  // A quad transfer that is not final moves on to the next corner
  a_quad_advance: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast
      |=> m_axis_tvalid && cnt == $past(cnt) + 3'd1)
    else $error("quad sequence broken");

  // Corner counter stays within the six corners
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> cnt <= 3'd5)
    else $error("corner counter out of range");

  // The y normal stays within unit magnitude
  a_norm_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> norm_y <= 16'sd16384 && norm_y >= -16'sd16384)
    else $error("normal out of range");

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

>>> sv/usph_div_cell.sv
// One cell of the angle divider chain: a restoring step on both angle lanes.
// Depends on usph_pkg for the lane and tag types.

module usph_div_cell #(
  parameter int STEP = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  usph_pkg::tag_t     tag_in,
  input  usph_pkg::div_lane_t th_in,
  input  usph_pkg::div_lane_t ph_in,
  output usph_pkg::tag_t     tag_out,
  output usph_pkg::div_lane_t th_out,
  output usph_pkg::div_lane_t ph_out
);

  // Numerator bit brought down by this cell
  localparam int BIT = usph_pkg::DIV_STEPS - 1 - STEP;

  function automatic usph_pkg::div_lane_t div_step(input usph_pkg::div_lane_t l);
    logic                      nb;
    logic [usph_pkg::REM_W:0]  t;
    logic [usph_pkg::REM_W:0]  dd;
    usph_pkg::div_lane_t       o;
    if (BIT == usph_pkg::DIV_STEPS - 1) nb = l.a0;
    else if (BIT < usph_pkg::SEG_W) nb = l.d[BIT % usph_pkg::SEG_W];
    else nb = 1'b0;
    t    = {l.r, nb};
    dd   = {1'b0, l.d, 1'b0};
    o    = l;
    if (t >= dd) begin
      o.r = usph_pkg::REM_W'(t - dd);
      o.q = {l.q[usph_pkg::DIV_STEPS-2:0], 1'b1};
    end else begin
      o.r = t[usph_pkg::REM_W-1:0];
      o.q = {l.q[usph_pkg::DIV_STEPS-2:0], 1'b0};
    end
    return o;
  endfunction

  // Advance the tag with the chain
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_out.valid <= 1'b0;
    end else if (en) begin
      tag_out <= tag_in;
    end
  end

  // Advance both lanes one quotient bit
  always_ff @(posedge clk) begin
    if (en) begin
      th_out <= div_step(th_in);
      ph_out <= div_step(ph_in);
    end
  end

endmodule

>>> sv/usph_cordic_cell.sv
// One cell of the CORDIC chain: a single micro-rotation on both angle lanes.
// Depends on usph_pkg for the lane type and the arctangent table.

module usph_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  usph_pkg::tag_t      tag_in,
  input  usph_pkg::cor_lane_t th_in,
  input  usph_pkg::cor_lane_t ph_in,
  output usph_pkg::tag_t      tag_out,
  output usph_pkg::cor_lane_t th_out,
  output usph_pkg::cor_lane_t ph_out
);

  localparam logic signed [usph_pkg::ANG_W-1:0] ATAN = usph_pkg::atan_turn(STEP);

  function automatic usph_pkg::cor_lane_t rotate(input usph_pkg::cor_lane_t l);
    logic signed [usph_pkg::ANG_W-1:0] dx;
    logic signed [usph_pkg::ANG_W-1:0] dy;
    usph_pkg::cor_lane_t               o;
    dx = $signed(l.y) >>> STEP;
    dy = $signed(l.x) >>> STEP;
    o  = l;
    if (!l.z[usph_pkg::ANG_W-1]) begin
      o.x = l.x - dx;
      o.y = l.y + dy;
      o.z = l.z - ATAN;
    end else begin
      o.x = l.x + dx;
      o.y = l.y - dy;
      o.z = l.z + ATAN;
    end
    return o;
  endfunction

  // Advance the tag with the chain
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_out.valid <= 1'b0;
    end else if (en) begin
      tag_out <= tag_in;
    end
  end

  // Rotate both lanes towards zero residual angle
  always_ff @(posedge clk) begin
    if (en) begin
      th_out <= rotate(th_in);
      ph_out <= rotate(ph_in);
    end
  end

endmodule
